// File: hdl/stable_record_sorter_by_key_core_defines.svh
// ----------------------------------------------------------------------------
// Stable record sorter assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STABLE_RECORD_SORTER_BY_KEY_CORE_DEFINES_SVH
`define STABLE_RECORD_SORTER_BY_KEY_CORE_DEFINES_SVH

// same-cycle implication
`define SRS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SRS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/srs_pkg.sv
// ----------------------------------------------------------------------------
// Stable record sorter package
// Sizes, record and cell control types shared by the sorter modules.
// ----------------------------------------------------------------------------
package srs_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int KEY_BITS  = 32;
	localparam int PRICE_W   = 32;
	localparam int TAG_W     = 6;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [PRICE_W-1:0]  price_t;
	typedef logic [TAG_W-1:0]    tag_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	typedef struct packed {
		logic valid;
		key_t key;
		tag_t tag;
	} rec_t;

	typedef struct packed {
		logic ins;
		logic pop;
		key_t key;
		tag_t tag;
	} cell_ctl_t;

endpackage

// File: hdl/srs_cell.sv
// ----------------------------------------------------------------------------
// Sorter insertion cell
// Holds one record; takes the new record, its upper neighbor's record on
// insertion, or its lower neighbor's record while the chain drains.
// ----------------------------------------------------------------------------
module srs_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  srs_pkg::cell_ctl_t ctl,
	input  logic               prv_cond,
	input  srs_pkg::rec_t      prv,
	input  srs_pkg::rec_t      nxt,
	output logic               cond,
	output srs_pkg::rec_t      rec
);

	logic          valid_q;
	srs_pkg::key_t key_q;
	srs_pkg::tag_t tag_q;

	// empty, or holding a strictly greater key: the new record goes here or above
	assign cond = !valid_q || (key_q > ctl.key);

	assign rec.valid = valid_q;
	assign rec.key   = key_q;
	assign rec.tag   = tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.pop) begin
			valid_q <= nxt.valid;
		end else if (ctl.ins && cond) begin
			valid_q <= prv_cond ? prv.valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			key_q <= nxt.key;
			tag_q <= nxt.tag;
		end else if (ctl.ins && cond) begin
			if (prv_cond) begin
				key_q <= prv.key;
				tag_q <= prv.tag;
			end else begin
				key_q <= ctl.key;
				tag_q <= ctl.tag;
			end
		end
	end

endmodule

// File: hdl/stable_record_sorter_by_key_core.sv
// ----------------------------------------------------------------------------
// Stable record sorter core
// Loads keyed records into a chain of insertion cells and emits them in
// ascending key order, equal keys in arrival order.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one record per beat, price, tag, last.
// Each beat is placed in sorted position in the cell chain, so a set loads
// at one beat per cycle. Beats beyond MAX_ITEMS are dropped and mark the
// set with overflow.
// A beat with last starts the drain: in_ready falls and cell 0 is shifted
// into the output register once per cycle, so a set of N records comes out
// as N beats on out_valid/out_ready, one beat per cycle while out_ready
// is high.
// end_of_run marks the final beat; overflow is the same on every beat of a set.
// A stalled receiver holds the output register and freezes the chain; the
// input stays closed until the final beat of the set sits in the output
// register, and loading of the next set may then start at once.
// Reset empties the chain, clears the count, the drop flag, the drain flag and out_valid.
// ----------------------------------------------------------------------------
`include "stable_record_sorter_by_key_core_defines.svh"

module stable_record_sorter_by_key_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [31:0]            price,
	input  logic [5:0]             tag,
	input  logic                   last,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [31:0]            sorted_price,
	output logic [5:0]             sorted_tag,
	output logic                   end_of_run,
	output logic                   overflow
);

	srs_pkg::cnt_t      fill_q;
	logic               drop_q;
	logic               drain_q;
	logic               out_valid_q;
	srs_pkg::price_t    sorted_price_q;
	srs_pkg::tag_t      sorted_tag_q;
	logic               end_q;
	logic               ovf_q;
	logic               full;
	logic               in_acc;
	logic               pop;
	srs_pkg::cell_ctl_t ctl;

	srs_pkg::rec_t rec      [srs_pkg::MAX_ITEMS];
	srs_pkg::rec_t prv_rec  [srs_pkg::MAX_ITEMS];
	srs_pkg::rec_t nxt_rec  [srs_pkg::MAX_ITEMS];
	logic          cond     [srs_pkg::MAX_ITEMS];
	logic          prv_cond [srs_pkg::MAX_ITEMS];
	logic [srs_pkg::MAX_ITEMS-1:0] vld;

	assign in_ready = !drain_q;
	assign in_acc   = in_valid && in_ready;
	assign full     = fill_q == srs_pkg::cnt_t'(srs_pkg::MAX_ITEMS);
	assign pop      = drain_q && (!out_valid_q || out_ready);

	assign ctl.ins = in_acc && !full;
	assign ctl.pop = pop;
	assign ctl.key = srs_pkg::key_t'(price);
	assign ctl.tag = tag;

	for (genvar i = 0; i < srs_pkg::MAX_ITEMS; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prv_rec[i]  = '0;
			assign prv_cond[i] = 1'b0;
		end else begin : g_body
			assign prv_rec[i]  = rec[i-1];
			assign prv_cond[i] = cond[i-1];
		end
		if (i == srs_pkg::MAX_ITEMS - 1) begin : g_tail
			assign nxt_rec[i] = '0;
		end else begin : g_link
			assign nxt_rec[i] = rec[i+1];
		end
		assign vld[i] = rec[i].valid;

		srs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.prv_cond (prv_cond[i]),
			.prv      (prv_rec[i]),
			.nxt      (nxt_rec[i]),
			.cond     (cond[i]),
			.rec      (rec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			drop_q  <= 1'b0;
			drain_q <= 1'b0;
		end else if (in_acc) begin
			if (full) begin
				drop_q <= 1'b1;
			end else begin
				fill_q <= fill_q + srs_pkg::cnt_t'(1);
			end
			if (last) begin
				drain_q <= 1'b1;
			end
		end else if (pop) begin
			fill_q <= fill_q - srs_pkg::cnt_t'(1);
			if (fill_q == srs_pkg::cnt_t'(1)) begin
				drain_q <= 1'b0;
				drop_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sorted_price_q <= srs_pkg::price_t'(rec[0].key);
			sorted_tag_q   <= rec[0].tag;
			end_q          <= fill_q == srs_pkg::cnt_t'(1);
			ovf_q          <= drop_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sorted_price = sorted_price_q;
	assign sorted_tag   = sorted_tag_q;
	assign end_of_run   = end_q;
	assign overflow     = ovf_q;

	`SRS_ASSERT_IMP(a_count_match, 1'b1, $countones(vld) == int'(fill_q), "fill count mismatch")
	`SRS_ASSERT_IMP(a_drain_nonempty, drain_q, fill_q != '0, "drain with empty chain")
	`SRS_ASSERT_NXT(a_last_drains, in_acc && last, drain_q, "last beat did not start drain")

	for (genvar j = 0; j < srs_pkg::MAX_ITEMS - 1; j++) begin : g_chk
		`SRS_ASSERT_IMP(a_prefix, !vld[j], !vld[j+1], "hole in cell chain")
		`SRS_ASSERT_IMP(a_order, vld[j] && vld[j+1], rec[j].key <= rec[j+1].key, "chain out of order")
	end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Stable record sorter testbench
// Sends sets of keyed records with random gaps on both channels, keeps its
// own insertion-ordered copy of each set and checks every sorted beat:
// ascending keys, equal keys in arrival order, end of run and drop marking.
// ----------------------------------------------------------------------------
module tb;

	localparam int QUIET_LIMIT    = 1000;
	localparam int TARGET_RECORDS = 500;
	localparam int MAX_WAIT       = 13;

	typedef struct packed {
		srs_pkg::key_t key;
		srs_pkg::tag_t tag;
	} held_rec_t;

	typedef struct packed {
		srs_pkg::price_t price;
		srs_pkg::tag_t   tag;
		logic            end_of_run;
		logic            overflow;
	} sorted_beat_t;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	srs_pkg::price_t price;
	srs_pkg::tag_t   tag;
	logic            last;
	logic            out_valid;
	logic            out_ready;
	srs_pkg::price_t sorted_price;
	srs_pkg::tag_t   sorted_tag;
	logic            end_of_run;
	logic            overflow;

	held_rec_t    held[$];
	logic         held_dropped = 1'b0;
	sorted_beat_t sorted_expect[$];

	int errors        = 0;
	int records_sent  = 0;
	int sets_sent     = 0;
	int dropped_sets  = 0;
	int beats_checked = 0;
	int tx_gap        = 0;
	bit tx_idle       = 1'b1;
	bit rx_idle       = 1'b1;

	stable_record_sorter_by_key_core i_dut (.*);

	always #2 clk = ~clk;

	// Place after every held key that is less or equal; emit the set on last.
	function automatic void predict_record(srs_pkg::price_t p, srs_pkg::tag_t t, logic l);
		srs_pkg::key_t k;
		int            pos;
		k = srs_pkg::key_t'(p);
		if (held.size() < srs_pkg::MAX_ITEMS) begin
			pos = 0;
			while (pos < held.size() && held[pos].key <= k)
				pos++;
			held.insert(pos, held_rec_t'{key: k, tag: t});
		end else begin
			held_dropped = 1'b1;
		end
		if (l) begin
			foreach (held[i])
				sorted_expect.push_back(sorted_beat_t'{
					price:      srs_pkg::price_t'(held[i].key),
					tag:        held[i].tag,
					end_of_run: (i == held.size() - 1),
					overflow:   held_dropped});
			sets_sent++;
			if (held_dropped)
				dropped_sets++;
			held.delete();
			held_dropped = 1'b0;
		end
	endfunction

	function automatic srs_pkg::price_t draw_price();
		case ($urandom_range(0, 3))
			0: return srs_pkg::price_t'($urandom_range(0, 7));
			1: return 32'hFFFF_FFF8 | srs_pkg::price_t'($urandom_range(0, 7));
			2: return srs_pkg::price_t'(1) << $urandom_range(0, 31);
			default: return srs_pkg::price_t'($urandom);
		endcase
	endfunction

	task automatic send_record(srs_pkg::price_t p, srs_pkg::tag_t t, logic l);
		repeat (tx_gap) @(posedge clk);
		in_valid <= 1'b1;
		price    <= p;
		tag      <= t;
		last     <= l;
		do @(posedge clk); while (!in_ready);
		predict_record(p, t, l);
		records_sent++;
		tx_gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
		if (tx_gap != 0)
			in_valid <= 1'b0;
	endtask

	// Drop valid unless the last send already did.
	task automatic hold_input();
		if (tx_gap == 0)
			in_valid <= 1'b0;
		tx_gap = 0;
		@(posedge clk);
	endtask

	task automatic pause_until_drained();
		hold_input();
		while (sorted_expect.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_single_records();
		send_record(32'hFFFF_FFFF, 6'd63, 1'b1);
		pause_until_drained();
		send_record(32'h0, 6'd0, 1'b1);
	endtask

	task automatic test_equal_keys();
		send_record(32'd7, 6'd10, 1'b0);
		send_record(32'd3, 6'd11, 1'b0);
		send_record(32'd7, 6'd12, 1'b0);
		send_record(32'd3, 6'd13, 1'b0);
		send_record(32'd0, 6'd14, 1'b0);
		send_record(32'hFFFF_FFFF, 6'd15, 1'b0);
		send_record(32'd7, 6'd16, 1'b1);
	endtask

	task automatic test_key_extremes();
		send_record(32'hFFFF_FFFF, 6'd1, 1'b0);
		send_record(32'h8000_0000, 6'd2, 1'b0);
		send_record(32'h7FFF_FFFF, 6'd3, 1'b0);
		send_record(32'h1, 6'd4, 1'b0);
		send_record(32'h0, 6'd5, 1'b1);
		send_record(32'hAAAA_AAAA, 6'h2A, 1'b0);
		send_record(32'h5555_5555, 6'h15, 1'b1);
	endtask

	// Exactly full, full with a dropped last, and several drops ending with a dropped last.
	task automatic test_store_full();
		int sizes[3] = '{srs_pkg::MAX_ITEMS, srs_pkg::MAX_ITEMS + 1, srs_pkg::MAX_ITEMS + 3};
		foreach (sizes[s]) begin
			tx_idle = (s != 0);
			rx_idle = (s != 1);
			for (int i = 0; i < sizes[s]; i++)
				send_record(draw_price(), srs_pkg::tag_t'($urandom_range(0, 63)),
					i == sizes[s] - 1);
			pause_until_drained();
		end
	endtask

	task automatic test_random_sets();
		int len;
		int pick;
		while (records_sent < TARGET_RECORDS) begin
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 19);
			if (pick < 14)
				len = $urandom_range(1, 8);
			else if (pick < 18)
				len = $urandom_range(9, 40);
			else
				len = $urandom_range(41, srs_pkg::MAX_ITEMS);
			for (int i = 0; i < len; i++)
				send_record(draw_price(), srs_pkg::tag_t'($urandom_range(0, 63)),
					i == len - 1);
			if ($urandom_range(0, 7) == 0)
				pause_until_drained();
		end
	endtask

	initial begin : receiver
		int stall;
		out_ready <= 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin : check_beats
		sorted_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (sorted_expect.size() == 0) begin
				$error("sorted beat with nothing expected: price %0h tag %0d",
					sorted_price, sorted_tag);
				errors++;
			end else begin
				want = sorted_expect.pop_front();
				beats_checked++;
				if (sorted_price !== want.price) begin
					$error("sorted_price: expected %0h, got %0h", want.price, sorted_price);
					errors++;
				end
				if (sorted_tag !== want.tag) begin
					$error("sorted_tag: expected %0d, got %0d", want.tag, sorted_tag);
					errors++;
				end
				if (end_of_run !== want.end_of_run) begin
					$error("end_of_run: expected %0b, got %0b", want.end_of_run, end_of_run);
					errors++;
				end
				if (overflow !== want.overflow) begin
					$error("overflow: expected %0b, got %0b", want.overflow, overflow);
					errors++;
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no beat for %0d cycles", QUIET_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		price    <= '0;
		tag      <= '0;
		last     <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_records();
		test_equal_keys();
		test_key_extremes();
		test_store_full();
		test_random_sets();
		pause_until_drained();
		repeat (8) @(posedge clk);
		$display("Sent %0d records in %0d sets, %0d of them with dropped records;",
			records_sent, sets_sent, dropped_sets);
		$display("checked %0d sorted beats with random stalls on both channels.",
			beats_checked);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
